// ----- rtl/sps_pkg.sv -----
// Shared constants and types for the packet scatter block.
// No dependencies; compiled first.
package sps_pkg;

    localparam int SLAB_ADDR_BITS = 20;
    localparam int MAX_DIM        = 1024;
    localparam int DIM_BITS       = $clog2(MAX_DIM);
    localparam int SIZE_BITS      = DIM_BITS + 1;
    localparam int WORD_BITS      = 32;
    localparam int CFG_DATA_BITS  = 11;
    localparam int CFG_INDEX_BITS = 2;
    localparam int AREA_BITS      = 2 * CFG_DATA_BITS;
    localparam int SLAB_BITS      = 3 * CFG_DATA_BITS;
    localparam int CMP_BITS       = (SLAB_BITS > WORD_BITS ? SLAB_BITS : WORD_BITS) + 2;
    localparam int ROWP_BITS      = SIZE_BITS + CFG_DATA_BITS;
    localparam int POS_BITS       = 3;

    localparam logic [CMP_BITS-1:0] ADDR_LIMIT = CMP_BITS'(1) << SLAB_ADDR_BITS;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DIM_X = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DIM_Y = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DIM_Z = 2'd2;

    // header word positions
    localparam logic [POS_BITS-1:0] HDR_ORIGIN_X = 3'd0;
    localparam logic [POS_BITS-1:0] HDR_ORIGIN_Y = 3'd1;
    localparam logic [POS_BITS-1:0] HDR_SIZE_X   = 3'd2;
    localparam logic [POS_BITS-1:0] HDR_SIZE_Y   = 3'd3;
    localparam logic [POS_BITS-1:0] HDR_START    = 3'd4;

    // first word value announcing a header in words 1 to 5
    localparam logic [WORD_BITS-1:0] TYPE_DATA_OFFSET = '1;

    localparam int SETTLE_CYCLES = 2;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] dim_x;
        logic [AREA_BITS-1:0]     area;
        logic [SLAB_BITS-1:0]     slab;
        logic                     settling;
    } t_cfg;

endpackage

// ----- rtl/sps_ifs.sv -----
// Channel interfaces of the packet scatter block: input words, writes, config.
// Depends on sps_pkg.
interface sps_in_if import sps_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] word;
    logic                 last;
    modport source (output valid, word, last, input ready);
    modport sink   (input valid, word, last, output ready);
endinterface

interface sps_out_if import sps_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [SLAB_ADDR_BITS-1:0] write_address;
    logic [WORD_BITS-1:0]      write_data;
    logic                      dropped;
    modport source (output valid, write_address, write_data, dropped, input ready);
    modport sink   (input valid, write_address, write_data, dropped, output ready);
endinterface

interface sps_cfg_if import sps_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/sps_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on sps_pkg.
module sps_div import sps_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WORD_BITS-1:0] i_dividend,
    input  logic [SIZE_BITS-1:0] i_divisor,
    output logic                 o_done,
    output logic [WORD_BITS-1:0] o_quot,
    output logic [DIM_BITS-1:0]  o_rem
);
    localparam int CNT_BITS = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] r_q;
    logic [DIM_BITS-1:0]  r_rem;
    logic [SIZE_BITS-1:0] r_div;
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIM_BITS:0]    w_trial;
    logic [DIM_BITS:0]    w_diff;
    logic                 w_fit;

    assign w_trial = {r_rem, r_q[WORD_BITS-1]};
    assign w_fit   = {1'b0, w_trial} >= {1'b0, r_div};
    assign w_diff  = w_trial - (DIM_BITS+1)'(r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[WORD_BITS-2:0], w_fit};
                r_rem <= w_fit ? w_diff[DIM_BITS-1:0] : w_trial[DIM_BITS-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(WORD_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

// ----- rtl/sps_cfg.sv -----
// Slab dimension registers, derived slab area and size products.
// Depends on sps_pkg and sps_cfg_if.
module sps_cfg import sps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sps_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);
    localparam int SET_BITS = $clog2(SETTLE_CYCLES + 1);

    logic [CFG_DATA_BITS-1:0] r_dim_x;
    logic [CFG_DATA_BITS-1:0] r_dim_y;
    logic [CFG_DATA_BITS-1:0] r_dim_z;
    logic [AREA_BITS-1:0]     r_area;
    logic [SLAB_BITS-1:0]     r_slab;
    logic [SET_BITS-1:0]      r_settle;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x  <= CFG_DATA_BITS'(64);
            r_dim_y  <= CFG_DATA_BITS'(64);
            r_dim_z  <= CFG_DATA_BITS'(8);
            r_settle <= SET_BITS'(SETTLE_CYCLES);
        end else if (i_cfg.valid) begin
            r_settle <= SET_BITS'(SETTLE_CYCLES);
            case (i_cfg.index)
                CFG_DIM_X: r_dim_x <= i_cfg.data;
                CFG_DIM_Y: r_dim_y <= i_cfg.data;
                CFG_DIM_Z: r_dim_z <= i_cfg.data;
                default: ;
            endcase
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 1'b1;
        end
    end

    // products are registered: area from the dimension registers, slab from area
    always_ff @(posedge i_clk) begin
        r_area <= {{CFG_DATA_BITS{1'b0}}, r_dim_x} * {{CFG_DATA_BITS{1'b0}}, r_dim_y};
        r_slab <= {{CFG_DATA_BITS{1'b0}}, r_area} * {{AREA_BITS{1'b0}}, r_dim_z};
    end

    assign o_cfg.dim_x    = r_dim_x;
    assign o_cfg.area     = r_area;
    assign o_cfg.slab     = r_slab;
    assign o_cfg.settling = (r_settle != '0);
endmodule

// ----- rtl/subblock_packet_scatter.sv -----
// Packet scatter top level: message parser, header sequencer, address walk.
// Depends on sps_pkg, sps_ifs, sps_div and sps_cfg.
//
// i_in carries message words (network byte order) with last on the final
// word. Header words are absorbed; each payload word gives one transaction
// on o_out: slab address, byte-reversed data and a dropped flag (address
// beyond the slab or past 2^20, address then reads 0). i_cfg writes
// slab_dim_x/y/z at indexes 0, 1, 2; it is always ready.
// A payload transaction is offered on o_out the cycle after its word is
// accepted. The start-index word, unless it carries last, runs two passes
// of the shared divider, then a multiply and an add state, during which
// i_in is not ready. Within a message's payload the sustained rate is one
// word per cycle while o_out takes every write and no config write settles.
// A config write, and reset, hold i_in off while the slab area and size
// products settle. Reset returns to awaiting a first word with default
// dimensions 64 x 64 x 8.
// The result sits in an output register; a stalled receiver holds it and
// keeps i_in not ready until the register drains.
module subblock_packet_scatter import sps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sps_cfg_if.sink     i_cfg,
    sps_in_if.sink      i_in,
    sps_out_if.source   o_out
);
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV1 = 5'b00010,
        ST_DIV2 = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_ADD  = 5'b10000
    } t_state;

    typedef enum logic [3:0] {
        MD_IDLE    = 4'b0001,
        MD_HEADER  = 4'b0010,
        MD_PAYLOAD = 4'b0100,
        MD_IGNORE  = 4'b1000
    } t_mode;

    t_cfg                      w_cfg;
    t_state                    r_state;
    t_mode                     r_mode;
    logic [POS_BITS-1:0]       r_pos;
    logic [DIM_BITS-1:0]       r_org_x;
    logic [DIM_BITS-1:0]       r_org_y;
    logic [SIZE_BITS-1:0]      r_bsx;
    logic [SIZE_BITS-1:0]      r_bsy;
    logic [DIM_BITS-1:0]       r_col;
    logic [DIM_BITS-1:0]       r_row;
    logic [WORD_BITS-1:0]      r_addr;
    logic [WORD_BITS-1:0]      r_plane_prod;
    logic [ROWP_BITS-1:0]      r_row_prod;
    logic [ROWP_BITS-1:0]      r_bsy_dx;
    logic                      r_out_valid;
    logic [SLAB_ADDR_BITS-1:0] r_out_addr;
    logic [WORD_BITS-1:0]      r_out_data;
    logic                      r_out_drop;

    logic                      w_ready;
    logic                      w_acc;
    logic [WORD_BITS-1:0]      w_word;
    logic [SIZE_BITS-1:0]      w_clamp;
    logic                      w_div_start;
    logic [WORD_BITS-1:0]      w_div_dividend;
    logic [SIZE_BITS-1:0]      w_div_divisor;
    logic                      w_div_done;
    logic [WORD_BITS-1:0]      w_div_quot;
    logic [DIM_BITS-1:0]       w_div_rem;
    logic                      w_drop;
    logic [SIZE_BITS-1:0]      w_col_inc;
    logic [SIZE_BITS-1:0]      w_row_inc;
    logic [SIZE_BITS-1:0]      w_row_abs;
    logic [WORD_BITS-1:0]      w_addr_row;

    sps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    sps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    assign w_word  = i_in.word;
    assign w_ready = (r_state == ST_IDLE) && !w_cfg.settling && (!r_out_valid || o_out.ready);
    assign w_acc   = i_in.valid && w_ready;
    assign w_clamp = (w_word > WORD_BITS'(MAX_DIM)) ? SIZE_BITS'(MAX_DIM)
                                                    : w_word[SIZE_BITS-1:0];

    assign w_div_start = (w_acc && r_mode == MD_HEADER && r_pos == HDR_START && !i_in.last)
                      || (r_state == ST_DIV1 && w_div_done);
    assign w_div_dividend = (r_state == ST_DIV1) ? w_div_quot : w_word;
    assign w_div_divisor  = (r_state == ST_DIV1) ? r_bsy : r_bsx;

    assign w_drop = ({{(CMP_BITS-WORD_BITS){1'b0}}, r_addr} >=
                     {{(CMP_BITS-SLAB_BITS){1'b0}}, w_cfg.slab})
                 || ({{(CMP_BITS-WORD_BITS){1'b0}}, r_addr} >= ADDR_LIMIT);

    assign w_col_inc  = {1'b0, r_col} + 1'b1;
    assign w_row_inc  = {1'b0, r_row} + 1'b1;
    assign w_row_abs  = {1'b0, r_row} + {1'b0, r_org_y};
    assign w_addr_row = r_addr + 1'b1 + WORD_BITS'(w_cfg.dim_x) - WORD_BITS'(r_bsx);

    always_ff @(posedge i_clk) begin
        r_bsy_dx <= {{CFG_DATA_BITS{1'b0}}, r_bsy} * {{SIZE_BITS{1'b0}}, w_cfg.dim_x};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MD_IDLE;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        unique case (r_mode)
                            MD_IDLE: begin
                                r_pos <= '0;
                                if (w_word == TYPE_DATA_OFFSET) begin
                                    r_mode <= MD_HEADER;
                                end else if (!w_word[WORD_BITS-1]) begin
                                    r_mode  <= MD_HEADER;
                                    r_org_x <= w_word[DIM_BITS-1:0];
                                    r_pos   <= HDR_ORIGIN_Y;
                                end else begin
                                    r_mode <= MD_IGNORE;
                                end
                            end
                            MD_HEADER: begin
                                case (r_pos)
                                    HDR_ORIGIN_X: begin
                                        r_org_x <= w_word[DIM_BITS-1:0];
                                        r_pos   <= r_pos + 1'b1;
                                    end
                                    HDR_ORIGIN_Y: begin
                                        r_org_y <= w_word[DIM_BITS-1:0];
                                        r_pos   <= r_pos + 1'b1;
                                    end
                                    HDR_SIZE_X: begin
                                        r_bsx <= w_clamp;
                                        if (w_clamp == '0) begin
                                            r_mode <= MD_IGNORE;
                                        end else begin
                                            r_pos <= r_pos + 1'b1;
                                        end
                                    end
                                    HDR_SIZE_Y: begin
                                        r_bsy <= w_clamp;
                                        if (w_clamp == '0) begin
                                            r_mode <= MD_IGNORE;
                                        end else begin
                                            r_pos <= r_pos + 1'b1;
                                        end
                                    end
                                    HDR_START: begin
                                        if (!i_in.last) begin
                                            r_state <= ST_DIV1;
                                        end
                                    end
                                    default: r_mode <= MD_IGNORE;
                                endcase
                            end
                            MD_PAYLOAD: begin
                                r_out_valid <= 1'b1;
                                r_out_addr  <= w_drop ? '0 : r_addr[SLAB_ADDR_BITS-1:0];
                                r_out_data  <= {w_word[7:0], w_word[15:8],
                                                w_word[23:16], w_word[31:24]};
                                r_out_drop  <= w_drop;
                                if (w_col_inc >= r_bsx) begin
                                    r_col <= '0;
                                    if (w_row_inc >= r_bsy) begin
                                        r_row  <= '0;
                                        r_addr <= w_addr_row + WORD_BITS'(w_cfg.area)
                                                - WORD_BITS'(r_bsy_dx);
                                    end else begin
                                        r_row  <= w_row_inc[DIM_BITS-1:0];
                                        r_addr <= w_addr_row;
                                    end
                                end else begin
                                    r_col  <= w_col_inc[DIM_BITS-1:0];
                                    r_addr <= r_addr + 1'b1;
                                end
                            end
                            MD_IGNORE: ;
                        endcase
                        if (i_in.last) begin
                            r_mode <= MD_IDLE;
                            r_pos  <= '0;
                        end
                    end
                end
                ST_DIV1: begin
                    if (w_div_done) begin
                        r_col   <= w_div_rem;
                        r_state <= ST_DIV2;
                    end
                end
                ST_DIV2: begin
                    if (w_div_done) begin
                        r_row   <= w_div_rem;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_plane_prod <= WORD_BITS'(w_div_quot * WORD_BITS'(w_cfg.area));
                    r_row_prod   <= {{CFG_DATA_BITS{1'b0}}, w_row_abs}
                                  * {{SIZE_BITS{1'b0}}, w_cfg.dim_x};
                    r_state      <= ST_ADD;
                end
                ST_ADD: begin
                    r_addr  <= r_plane_prod + WORD_BITS'(r_row_prod)
                             + WORD_BITS'(r_col) + WORD_BITS'(r_org_x);
                    r_mode  <= MD_PAYLOAD;
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready          = w_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.write_address = r_out_addr;
    assign o_out.write_data    = r_out_data;
    assign o_out.dropped       = r_out_drop;
endmodule

// ----- verif/subblock_packet_scatter_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for subblock_packet_scatter: streams messages into the block,
// predicts every slab write and compares it with the output transactions.
// Depends on sps_pkg, the sps_ifs channel interfaces and the RTL top level.
module subblock_packet_scatter_test;
    import sps_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int MAX_GAP        = 13;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_AFTER     = 300;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_WORDS    = 110;
    localparam int NUM_PHASES     = 8;

    localparam logic [WORD_BITS-1:0]      TYPE_INFO  = 32'hFFFF_FFFE;
    localparam logic [WORD_BITS-1:0]      DIM_CAP    = MAX_DIM;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {AWAIT_TYPE, IN_HEADER, IN_PAYLOAD, SKIP_REST} t_msg_mode;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 last;
    } t_msg_word;

    typedef struct packed {
        logic [SLAB_ADDR_BITS-1:0] addr;
        logic [WORD_BITS-1:0]      data;
        logic                      dropped;
    } t_write;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sps_cfg_if cfg_bus ();
    sps_in_if  in_bus ();
    sps_out_if out_bus ();

    subblock_packet_scatter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    t_msg_word pending_words[$];
    t_write    expected_writes[$];
    int        queued_words;
    int        error_count;

    // scatter state mirrored from the block
    logic [31:0]         dim_x, dim_y, dim_z;
    t_msg_mode           msg_mode;
    logic [POS_BITS-1:0] hdr_pos;
    logic [31:0]         org_x, org_y, blk_x, blk_y, col, row, write_ptr;

    int   in_gap, in_calm, out_gap, out_calm;
    int   hold_left, words_seen, idle_cycles;
    logic holding;

    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(10, 60);
        return $urandom_range(0, MAX_GAP);
    endfunction

    task automatic take_header(input logic [WORD_BITS-1:0] w);
        logic [63:0] quot, plane, base;
        case (hdr_pos)
            HDR_ORIGIN_X: org_x = w % DIM_CAP;
            HDR_ORIGIN_Y: org_y = w % DIM_CAP;
            HDR_SIZE_X: begin
                blk_x = (w > DIM_CAP) ? DIM_CAP : w;
                if (blk_x == 0) msg_mode = SKIP_REST;
            end
            HDR_SIZE_Y: begin
                blk_y = (w > DIM_CAP) ? DIM_CAP : w;
                if (blk_y == 0) msg_mode = SKIP_REST;
            end
            HDR_START: begin
                quot  = {32'd0, w} / blk_x;
                plane = quot / blk_y;
                col   = 32'({32'd0, w} % blk_x);
                row   = 32'(quot % blk_y);
                base  = plane * (dim_x * dim_y) + (row + org_y) * dim_x + col + org_x;
                write_ptr = base[31:0];
                msg_mode  = IN_PAYLOAD;
            end
            default: msg_mode = SKIP_REST;
        endcase
        if (msg_mode == IN_HEADER) hdr_pos = hdr_pos + 1'b1;
    endtask

    task automatic predict_word(input logic [WORD_BITS-1:0] w, input logic is_last);
        logic [63:0] slab;
        t_write      wr;
        case (msg_mode)
            AWAIT_TYPE: begin
                hdr_pos = HDR_ORIGIN_X;
                if (w == TYPE_DATA_OFFSET) begin
                    msg_mode = IN_HEADER;
                end else if (!w[31]) begin
                    msg_mode = IN_HEADER;
                    take_header(w);
                end else begin
                    msg_mode = SKIP_REST;
                end
            end
            IN_HEADER: take_header(w);
            IN_PAYLOAD: begin
                slab       = dim_x * dim_y * dim_z;
                wr.dropped = ({32'd0, write_ptr} >= slab) || (write_ptr >= ADDR_LIMIT);
                wr.addr    = wr.dropped ? '0 : write_ptr[SLAB_ADDR_BITS-1:0];
                wr.data    = {w[7:0], w[15:8], w[23:16], w[31:24]};
                expected_writes.push_back(wr);
                write_ptr = write_ptr + 1;
                col       = col + 1;
                if (col >= blk_x) begin
                    col       = 0;
                    write_ptr = write_ptr + dim_x - blk_x;
                    row       = row + 1;
                    if (row >= blk_y) begin
                        row       = 0;
                        write_ptr = write_ptr + dim_x * dim_y - blk_y * dim_x;
                    end
                end
            end
            default: ;
        endcase
        if (is_last) begin
            msg_mode = AWAIT_TYPE;
            hdr_pos  = HDR_ORIGIN_X;
        end
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] want_v, got_v);
        error_count++;
        $display("%0t: %s expected %h, got %h", $time, field, want_v, got_v);
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            in_bus.word  <= '0;
            in_bus.last  <= 1'b0;
            in_gap = 0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                void'(pending_words.pop_front());
                in_gap = draw_gap(in_calm);
            end
            if (in_gap > 0) begin
                in_gap--;
                in_bus.valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                in_bus.valid <= 1'b1;
                in_bus.word  <= pending_words[0].word;
                in_bus.last  <= pending_words[0].last;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off once the stream is well under way
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  = 0;
            words_seen = 0;
            holding <= 1'b0;
        end else begin
            if (hold_left > 0) hold_left--;
            if (in_bus.valid && in_bus.ready) begin
                words_seen++;
                if (words_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
            end
            holding <= (hold_left > 0);
        end
    end

    // monitor: prediction, output check and receiver ready
    always @(posedge i_clk) begin
        t_write got, want;
        if (!i_rst_n) begin
            dim_x     = 64;
            dim_y     = 64;
            dim_z     = 8;
            msg_mode  = AWAIT_TYPE;
            hdr_pos   = HDR_ORIGIN_X;
            org_x     = 0;
            org_y     = 0;
            blk_x     = 0;
            blk_y     = 0;
            col       = 0;
            row       = 0;
            write_ptr = 0;
            out_gap   = 0;
            out_bus.ready <= 1'b0;
        end else begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                case (cfg_bus.index)
                    CFG_DIM_X: dim_x = {21'd0, cfg_bus.data};
                    CFG_DIM_Y: dim_y = {21'd0, cfg_bus.data};
                    CFG_DIM_Z: dim_z = {21'd0, cfg_bus.data};
                    default: ;
                endcase
            end
            if (in_bus.valid && in_bus.ready) predict_word(in_bus.word, in_bus.last);
            if (out_bus.valid && out_bus.ready) begin
                got.addr    = out_bus.write_address;
                got.data    = out_bus.write_data;
                got.dropped = out_bus.dropped;
                if (expected_writes.size() == 0) begin
                    error_count++;
                    $display("%0t: write expected none, got addr %h data %h dropped %b",
                             $time, got.addr, got.data, got.dropped);
                end else begin
                    want = expected_writes.pop_front();
                    if (got.addr != want.addr) note_mismatch("write_address", want.addr, got.addr);
                    if (got.data != want.data) note_mismatch("write_data", want.data, got.data);
                    if (got.dropped != want.dropped)
                        note_mismatch("dropped", want.dropped, got.dropped);
                end
                out_gap = draw_gap(out_calm);
            end
            if (out_gap > 0) begin
                out_gap--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= !holding;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic push_word(input logic [WORD_BITS-1:0] w, input logic is_last);
        t_msg_word t;
        t.word = w;
        t.last = is_last;
        pending_words.push_back(t);
        queued_words++;
    endtask

    function automatic logic [WORD_BITS-1:0] pick_size();
        case ($urandom_range(0, 19))
            0:       return $urandom;
            1:       return DIM_CAP - $urandom_range(0, 1);
            2, 3:    return $urandom_range(9, 64);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    task automatic queue_message();
        logic [WORD_BITS-1:0] hdr [5];
        logic [WORD_BITS-1:0] msg [$];
        int   kind, span;
        logic long_form;
        kind   = $urandom_range(0, 99);
        hdr[0] = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
        hdr[1] = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
        hdr[2] = pick_size();
        hdr[3] = pick_size();
        span   = ((hdr[2] > 64) ? 64 : hdr[2]) * ((hdr[3] > 64) ? 64 : hdr[3]) * 2;
        hdr[4] = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, span);
        long_form = hdr[0][31] || ($urandom_range(0, 1) == 1);
        if (kind < 8) begin
            // ignored message types
            msg.push_back(($urandom_range(0, 1) == 1) ? TYPE_INFO : ($urandom | 32'h8000_0000));
            if (msg[0] == TYPE_DATA_OFFSET) msg[0] = TYPE_INFO;
            repeat ($urandom_range(0, 6)) msg.push_back($urandom);
        end else if (kind < 14) begin
            repeat ($urandom_range(1, 8)) msg.push_back($urandom);
        end else begin
            if (kind < 22) hdr[$urandom_range(2, 3)] = '0;
            if (long_form) msg.push_back(TYPE_DATA_OFFSET);
            foreach (hdr[i]) msg.push_back(hdr[i]);
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24))
                msg.push_back($urandom);
            // cut inside the header
            if (kind < 28) msg = msg[0:$urandom_range(0, long_form ? 5 : 4)];
        end
        foreach (msg[i]) push_word(msg[i], i == msg.size() - 1);
    endtask

    task automatic queue_words(input int count);
        int goal;
        goal = queued_words + count;
        while (queued_words < goal) queue_message();
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_writes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_dim(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin
        logic [2:0][CFG_DATA_BITS-1:0] plan;
        i_rst_n       = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_DIM_X;
        cfg_bus.data  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // offset header, payload crossing a row and a plane
        push_word(TYPE_DATA_OFFSET, 1'b0);
        push_word(32'd3, 1'b0);
        push_word(32'd2, 1'b0);
        push_word(32'd2, 1'b0);
        push_word(32'd2, 1'b0);
        push_word(32'd3, 1'b0);
        push_word(32'h1234_5678, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'h0000_0000, 1'b1);
        // header from word 0, origins wrapped, sizes saturated, start far out
        push_word(32'h7FFF_FFFF, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(DIM_CAP, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'hA5C3_0F81, 1'b1);
        // info message, other negative type
        push_word(TYPE_INFO, 1'b0);
        push_word(32'hDEAD_BEEF, 1'b1);
        push_word(32'h8000_0000, 1'b1);
        // zero block width
        push_word(32'd0, 1'b0);
        push_word(32'd0, 1'b0);
        push_word(32'd0, 1'b0);
        push_word(32'd5, 1'b0);
        push_word(32'd9, 1'b1);
        // truncated header
        push_word(TYPE_DATA_OFFSET, 1'b0);
        push_word(32'd1, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            case (p)
                0: plan = {11'd16, 11'd16, 11'd4};
                1: plan = {11'd1, 11'd1, 11'd1};
                2: plan = {11'd1024, 11'd1024, 11'd1024};
                3: plan = {11'd0, 11'd9, 11'd5};
                4: plan = {11'd2047, 11'd2047, 11'd2047};
                5: plan = {11'd7, 11'd13, 11'd3};
                6: plan = {11'd48, 11'd3, 11'd0};
                default: plan = {CFG_DATA_BITS'($urandom_range(1, 100)),
                                 CFG_DATA_BITS'($urandom_range(1, 100)),
                                 CFG_DATA_BITS'($urandom_range(1, 100))};
            endcase
            write_dim(CFG_DIM_X, plan[2]);
            write_dim(CFG_DIM_Y, plan[1]);
            write_dim(CFG_DIM_Z, plan[0]);
            write_dim(CFG_UNUSED, CFG_DATA_BITS'($urandom));
            @(negedge i_clk);
            queue_words(PHASE_WORDS);
        end
        wait_drained();

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
